FILE: rtl/aftx_pkg.sv
// Package for the escaped transmit-request frame builder.
// Holds the beat types, the frame constants and the escape test; no dependencies.
`default_nettype none

package aftx_pkg;

  localparam logic [7:0] FRAME_DELIM  = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] XON_BYTE     = 8'h11;
  localparam logic [7:0] XOFF_BYTE    = 8'h13;
  localparam logic [7:0] ESC_FLIP     = 8'h20;
  localparam logic [7:0] CSUM_BASE    = 8'hFF;
  localparam logic [8:0] HDR_FIXED    = 9'd14;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_API_IDENT   = 3'd0;
  localparam logic [2:0] REG_FRAME_IDENT = 3'd1;
  localparam logic [2:0] REG_DEST_LONG   = 3'd2;
  localparam logic [2:0] REG_DEST_SHORT  = 3'd3;
  localparam logic [2:0] REG_HOP_RADIUS  = 3'd4;
  localparam logic [2:0] REG_TX_OPTIONS  = 3'd5;

  // Raw byte positions walked by the back end
  localparam logic [4:0] IDX_DELIM   = 5'd0;
  localparam logic [4:0] IDX_LEN_HI  = 5'd1;
  localparam logic [4:0] IDX_LEN_LO  = 5'd2;
  localparam logic [4:0] IDX_API     = 5'd3;
  localparam logic [4:0] IDX_FRAME   = 5'd4;
  localparam logic [4:0] IDX_ADDR0   = 5'd5;
  localparam logic [4:0] IDX_ADDR7   = 5'd12;
  localparam logic [4:0] IDX_SHORT_H = 5'd13;
  localparam logic [4:0] IDX_SHORT_L = 5'd14;
  localparam logic [4:0] IDX_RADIUS  = 5'd15;
  localparam logic [4:0] IDX_OPTIONS = 5'd16;
  localparam logic [4:0] IDX_PAYLOAD = 5'd17;
  localparam logic [4:0] IDX_CSUM    = 5'd18;

  typedef struct packed {
    logic [7:0] pbyte;
    logic [7:0] len;
    logic       open;
    logic       last;
  } job_t;

  typedef struct packed {
    logic [7:0] lbyte;
    logic       frame_end;
    logic       run_last;
  } line_t;

  typedef struct packed {
    logic [7:0]  api_ident;
    logic [7:0]  frame_ident;
    logic [63:0] dest_addr_long;
    logic [15:0] dest_addr_short;
    logic [7:0]  hop_radius;
    logic [7:0]  tx_options;
  } hdr_cfg_t;

  function automatic logic needs_escape(input logic [7:0] b);
    needs_escape = (b == FRAME_DELIM) || (b == ESC_BYTE) ||
                   (b == XON_BYTE) || (b == XOFF_BYTE);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/aftx_fifo.sv
// Two-entry queue used between front and back, and in front of the result port.
// Generic over the beat width; no package dependency.
`default_nettype none

module aftx_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output logic [W-1:0]      dout
);

  logic [W-1:0] mem [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         do_wr, do_rd;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign dout  = mem[rd_ptr_r];
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/aftx_front.sv
// Front end: accepts payload beats, tracks the open frame and tags each beat.
// Depends on aftx_pkg for the job type.
`default_nettype none

module aftx_front
  import aftx_pkg::*;
#(
  parameter int MAX_PAYLOAD = 255
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] payload_byte,
  input  wire logic [7:0] payload_len,
  output job_t            job
);

  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] len_fix;
  logic [7:0] remain;

  always_comb begin
    len_fix = (payload_len == 8'd0) ? 8'd1 : payload_len;
    if (len_fix > 8'(MAX_PAYLOAD)) begin
      len_fix = 8'(MAX_PAYLOAD);
    end
    remain = (bytes_left_r == 8'd0) ? len_fix - 8'd1 : bytes_left_r - 8'd1;

    job.pbyte = payload_byte;
    job.len   = len_fix;
    job.open  = (bytes_left_r == 8'd0);
    job.last  = (remain == 8'd0);

    bytes_left_nxt = accept ? remain : bytes_left_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 8'd0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/aftx_back.sv
// Back end: walks the header, payload and checksum bytes of a frame and escapes them.
// Depends on aftx_pkg for job, line and header types.
`default_nettype none

module aftx_back
  import aftx_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_valid,
  input  job_t      job,
  output logic      job_pop,
  input  hdr_cfg_t  cfg,
  input  wire logic line_full,
  output logic      line_push,
  output line_t     line
);

  logic       active_r, active_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] sum_r, sum_nxt;

  logic [4:0] cur_idx;
  logic [7:0] raw;
  logic [8:0] total;
  logic [2:0] addr_sel;
  logic       fire;
  logic       advance;
  logic       job_done;
  logic       summed;

  always_comb begin
    cur_idx  = active_r ? idx_r : (job.open ? IDX_DELIM : IDX_PAYLOAD);
    total    = {1'b0, job.len} + HDR_FIXED;
    addr_sel = 3'(IDX_ADDR7 - cur_idx);

    case (cur_idx)
      IDX_DELIM:   raw = FRAME_DELIM;
      IDX_LEN_HI:  raw = {7'd0, total[8]};
      IDX_LEN_LO:  raw = total[7:0];
      IDX_API:     raw = cfg.api_ident;
      IDX_FRAME:   raw = cfg.frame_ident;
      IDX_SHORT_H: raw = cfg.dest_addr_short[15:8];
      IDX_SHORT_L: raw = cfg.dest_addr_short[7:0];
      IDX_RADIUS:  raw = cfg.hop_radius;
      IDX_OPTIONS: raw = cfg.tx_options;
      IDX_PAYLOAD: raw = job.pbyte;
      IDX_CSUM:    raw = CSUM_BASE - sum_r;
      default:     raw = cfg.dest_addr_long[{addr_sel, 3'b000} +: 8];
    endcase

    summed = (cur_idx >= IDX_API) && (cur_idx <= IDX_PAYLOAD);
    fire   = job_valid && !line_full;

    // Delimiter goes out raw; escaped bytes take two line beats
    if (esc_r) begin
      line.lbyte = raw ^ ESC_FLIP;
      advance    = fire;
    end else if ((cur_idx != IDX_DELIM) && needs_escape(raw)) begin
      line.lbyte = ESC_BYTE;
      advance    = 1'b0;
    end else begin
      line.lbyte = raw;
      advance    = fire;
    end

    job_done = advance &&
               ((cur_idx == IDX_CSUM) || ((cur_idx == IDX_PAYLOAD) && !job.last));
    line.frame_end = advance && (cur_idx == IDX_CSUM);
    line.run_last  = job_done;
    line_push      = fire;
    job_pop        = job_done;

    active_nxt = active_r;
    idx_nxt    = idx_r;
    esc_nxt    = esc_r;
    sum_nxt    = sum_r;
    if (fire) begin
      esc_nxt = !advance;
      if (advance) begin
        if (cur_idx == IDX_DELIM) begin
          sum_nxt = 8'd0;
        end else if (summed) begin
          sum_nxt = sum_r + raw;
        end
        if (job_done) begin
          active_nxt = 1'b0;
        end else begin
          active_nxt = 1'b1;
          idx_nxt    = cur_idx + 5'd1;
        end
      end else begin
        // Hold position for the second half of the escape
        active_nxt = 1'b1;
        idx_nxt    = cur_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= IDX_DELIM;
      esc_r    <= 1'b0;
      sum_r    <= 8'd0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      esc_r    <= esc_nxt;
      sum_r    <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/api_frame_tx_escaper.sv
// Top level of the escaped transmit-request frame builder.
// Uses aftx_pkg, aftx_front, aftx_fifo and aftx_back.
//
//   channel | ports                                          | handshake
//   --------+------------------------------------------------+-----------------
//   input   | in_payload_byte, in_payload_len                | in_push / in_full
//   result  | out_byte, out_frame_end, out_run_last          | out_empty / out_pop
//   config  | cfg_index, cfg_data                            | cfg_we
//
// The back end emits one line byte per cycle while a job waits and the result
// queue is not full. An escaped byte goes out as the escape byte, then the
// flipped byte; a frame-opening beat adds the 17 header bytes and the closing
// beat the checksum byte. A two-entry job queue and a two-entry result queue
// let each side stall on its own. Reset is synchronous on rst_n; no clearing pass.
`default_nettype none

module api_frame_tx_escaper
  import aftx_pkg::*;
#(
  parameter int MAX_PAYLOAD = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic [7:0]  in_payload_len,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_byte,
  output logic             out_frame_end,
  output logic             out_run_last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  hdr_cfg_t cfg_r;
  job_t     job_in, job_head;
  logic     job_empty, job_pop;
  logic     line_full, line_push;
  line_t    line_in, line_head;
  logic     in_accept;

  assign in_accept = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.api_ident       <= 8'h10;
      cfg_r.frame_ident     <= 8'h01;
      cfg_r.dest_addr_long  <= 64'h0000_0000_0000_FFFF;
      cfg_r.dest_addr_short <= 16'hFFFE;
      cfg_r.hop_radius      <= 8'h00;
      cfg_r.tx_options      <= 8'h00;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_API_IDENT:   cfg_r.api_ident       <= cfg_data[7:0];
        REG_FRAME_IDENT: cfg_r.frame_ident     <= cfg_data[7:0];
        REG_DEST_LONG:   cfg_r.dest_addr_long  <= cfg_data;
        REG_DEST_SHORT:  cfg_r.dest_addr_short <= cfg_data[15:0];
        REG_HOP_RADIUS:  cfg_r.hop_radius      <= cfg_data[7:0];
        REG_TX_OPTIONS:  cfg_r.tx_options      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  aftx_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .payload_byte (in_payload_byte),
    .payload_len  (in_payload_len),
    .job          (job_in)
  );

  aftx_fifo #(
    .W ($bits(job_t))
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (job_in),
    .full  (in_full),
    .pop   (job_pop),
    .empty (job_empty),
    .dout  (job_head)
  );

  aftx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .cfg       (cfg_r),
    .line_full (line_full),
    .line_push (line_push),
    .line      (line_in)
  );

  aftx_fifo #(
    .W ($bits(line_t))
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (line_push),
    .din   (line_in),
    .full  (line_full),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (line_head)
  );

  assign out_byte      = line_head.lbyte;
  assign out_frame_end = line_head.frame_end;
  assign out_run_last  = line_head.run_last;

endmodule

`default_nettype wire
